// ===== hw/rtl/indexed_max_heap_queue_core_macros.svh =====
// Assertion macros for the indexed max-heap queue.
// Included by the RTL files that carry concurrent assertions.
`ifndef INDEXED_MAX_HEAP_QUEUE_CORE_MACROS_SVH
`define INDEXED_MAX_HEAP_QUEUE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IMQ_ASSERT_IMP(lbl, clk, rst, ant, con) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
      else $error("assertion failed");
`define IMQ_ASSERT_NXT(lbl, clk, rst, ant, con) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
      else $error("assertion failed");
`else
`define IMQ_ASSERT_IMP(lbl, clk, rst, ant, con)
`define IMQ_ASSERT_NXT(lbl, clk, rst, ant, con)
`endif
`endif

// ===== hw/rtl/imq_pkg.sv =====
// Package of the indexed max-heap queue: sizes, codes and entry types.
// No dependencies.
`default_nettype none
package imq_pkg;
   localparam int HEAP_DEPTH = 1024;
   localparam int KEY_SPACE  = 4096;
   localparam int SLOT_W     = $clog2(HEAP_DEPTH);
   localparam int KEY_W      = $clog2(KEY_SPACE);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int VAL_W      = 32;

   localparam logic [1:0] MODE_OFFER  = 2'd0;
   localparam logic [1:0] MODE_POP    = 2'd1;
   localparam logic [1:0] MODE_BUMP   = 2'd2;
   localparam logic [1:0] MODE_INSERT = 2'd3;

   localparam logic [2:0] STAT_OK    = 3'd0;
   localparam logic [2:0] STAT_EMPTY = 3'd1;
   localparam logic [2:0] STAT_FULL  = 3'd2;
   localparam logic [2:0] STAT_TAKEN = 3'd3;
   localparam logic [2:0] STAT_RANGE = 3'd4;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [KEY_W-1:0]        key;
   } heap_entry_type;

   typedef struct packed {
      logic              present;
      logic [SLOT_W-1:0] slot;
   } map_entry_type;
endpackage
`default_nettype wire

// ===== hw/rtl/indexed_max_heap_queue_core.sv =====
// Indexed binary max-heap queue of (key, Q16.16 value) entries with key lookup.
// Uses imq_pkg, imq_ram and indexed_max_heap_queue_core_macros.svh.
//
// Usage:
//   req channel: tuser = mode (offer, pop, bump, insert), tdata = key, slot,
//   amount. rsp channel: tuser = status, tdata = key, value, entry count.
//   Every request gives exactly one response, in order.
//   One request is processed at a time. Each sift-up level steps through
//   S_UP_RD, S_UP_CK and S_UP_MV, and each sift-down level through S_DN_A
//   to S_DN_D (one heap RAM read port, one write port).
//   After reset a clearing pass writes all 4096 key-map and taken-mark
//   entries, one per cycle; req_tready stays low until the pass is done.
//   The response sits in an output register; a new request is accepted
//   while it waits, but the next response is held until rsp_tready takes
//   the previous one.
`default_nettype none
`include "indexed_max_heap_queue_core_macros.svh"
module indexed_max_heap_queue_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // key[11:0], slot[21:12], amount[53:22]
   input  wire logic [1:0]  req_tuser,  // mode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,  // out_key[11:0], out_value[43:12], entry_count[54:44]
   output logic [2:0]       rsp_tuser   // status[2:0]
);
   localparam int SW = imq_pkg::SLOT_W;
   localparam int KW = imq_pkg::KEY_W;
   localparam int CW = imq_pkg::CNT_W;
   localparam int VW = imq_pkg::VAL_W;
   localparam int HW = $bits(imq_pkg::heap_entry_type);
   localparam int MW = $bits(imq_pkg::map_entry_type);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_OFR_CK, S_ADD_CK, S_POP_RD, S_POP_CK,
      S_UP_RD, S_UP_CK, S_UP_MV, S_DN_A, S_DN_B, S_DN_C, S_DN_D, S_FIN
   } state_type;

   state_type                    state_ff, state_in;
   logic [KW-1:0]                key_ff, key_in;
   logic signed [VW-1:0]         amt_ff, amt_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [SW-1:0]                pos_ff, pos_in;
   imq_pkg::heap_entry_type      cur_ff, cur_in;
   imq_pkg::heap_entry_type      hold_ff, hold_in;
   logic signed [VW-1:0]         old_ff, old_in;
   logic                         moved_ff, moved_in;
   logic                         add_ff, add_in;
   logic [KW-1:0]                clr_ff, clr_in;
   logic [2:0]                   stat_ff, stat_in;
   logic [KW-1:0]                okey_ff, okey_in;
   logic signed [VW-1:0]         oval_ff, oval_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [2:0]                   rsp_stat_ff, rsp_stat_in;
   logic [KW-1:0]                rsp_key_ff, rsp_key_in;
   logic signed [VW-1:0]         rsp_val_ff, rsp_val_in;
   logic [CW-1:0]                rsp_cnt_ff, rsp_cnt_in;

   logic                         h_we;
   logic [SW-1:0]                h_waddr, h_raddr;
   imq_pkg::heap_entry_type      h_wdata, h_rdata;
   logic                         m_we;
   logic [KW-1:0]                m_waddr, m_raddr;
   imq_pkg::map_entry_type       m_wdata, m_rdata;
   logic                         k_we;
   logic                         k_wdata, k_rdata;

   logic [KW-1:0]                req_key;
   logic [SW-1:0]                req_slot;
   logic signed [VW-1:0]         req_amt;
   logic [SW-1:0]                par_idx;
   logic [CW:0]                  c1_idx, c2_idx;
   logic signed [VW:0]           sum;
   logic signed [VW-1:0]         sat_val;
   logic                         out_free;
   logic                         c2_ok, pick1;
   imq_pkg::heap_entry_type      child;
   logic                         walking;

   assign req_key  = req_tdata[11:0];
   assign req_slot = req_tdata[21:12];
   assign req_amt  = req_tdata[53:22];
   assign par_idx  = (pos_ff - SW'(1)) >> 1;
   assign c1_idx   = {1'b0, pos_ff, 1'b1};
   assign c2_idx   = c1_idx + (CW+1)'(1);
   assign sum      = {h_rdata.value[VW-1], h_rdata.value} + {amt_ff[VW-1], amt_ff};
   assign sat_val  = (sum[VW] != sum[VW-1]) ? {sum[VW], {(VW-1){~sum[VW]}}} : sum[VW-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign c2_ok    = c2_idx < {1'b0, cnt_ff};
   assign pick1    = !c2_ok || (hold_ff.value > h_rdata.value);
   assign child    = pick1 ? hold_ff : h_rdata;
   assign walking  = (state_ff == S_UP_RD) || (state_ff == S_UP_CK) ||
                     (state_ff == S_UP_MV) || (state_ff == S_DN_A) ||
                     (state_ff == S_DN_B) || (state_ff == S_DN_C) ||
                     (state_ff == S_DN_D);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = {1'b0, rsp_cnt_ff, rsp_val_ff, rsp_key_ff};

   always_comb begin
      state_in = state_ff;
      key_in = key_ff;
      amt_in = amt_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      cur_in = cur_ff;
      hold_in = hold_ff;
      old_in = old_ff;
      moved_in = moved_ff;
      add_in = add_ff;
      clr_in = clr_ff;
      stat_in = stat_ff;
      okey_in = okey_ff;
      oval_in = oval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_stat_in = rsp_stat_ff;
      rsp_key_in = rsp_key_ff;
      rsp_val_in = rsp_val_ff;
      rsp_cnt_in = rsp_cnt_ff;
      h_we = 1'b0;
      h_waddr = pos_ff;
      h_wdata = cur_ff;
      h_raddr = '0;
      m_we = 1'b0;
      m_waddr = key_ff;
      m_wdata = '0;
      m_raddr = req_key;
      k_we = 1'b0;
      k_wdata = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            m_we = 1'b1;
            k_we = 1'b1;
            m_waddr = clr_ff;
            clr_in = clr_ff + KW'(1);
            if (clr_ff == {KW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               key_in = req_key;
               amt_in = req_amt;
               stat_in = imq_pkg::STAT_OK;
               okey_in = '0;
               oval_in = '0;
               unique case (req_tuser)
                  imq_pkg::MODE_OFFER: begin
                     state_in = S_OFR_CK;
                  end
                  imq_pkg::MODE_POP: begin
                     if (cnt_ff == '0) begin
                        stat_in = imq_pkg::STAT_EMPTY;
                        state_in = S_FIN;
                     end else begin
                        state_in = S_POP_RD;
                     end
                  end
                  imq_pkg::MODE_BUMP: begin
                     if ({1'b0, req_slot} >= cnt_ff) begin
                        stat_in = imq_pkg::STAT_RANGE;
                        state_in = S_FIN;
                     end else begin
                        h_raddr = req_slot;
                        pos_in = req_slot;
                        state_in = S_ADD_CK;
                     end
                  end
                  default: begin
                     if (cnt_ff >= CW'(imq_pkg::HEAP_DEPTH)) begin
                        stat_in = imq_pkg::STAT_FULL;
                        state_in = S_FIN;
                     end else begin
                        pos_in = cnt_ff[SW-1:0];
                        cnt_in = cnt_ff + CW'(1);
                        cur_in = '{value: req_amt, key: req_key};
                        m_we = 1'b1;
                        m_waddr = req_key;
                        m_wdata = '{present: 1'b1, slot: cnt_ff[SW-1:0]};
                        moved_in = 1'b0;
                        add_in = 1'b0;
                        state_in = S_UP_RD;
                     end
                  end
               endcase
            end
         end
         S_OFR_CK: begin
            priority if (k_rdata) begin
               stat_in = imq_pkg::STAT_TAKEN;
               state_in = S_FIN;
            end else if (m_rdata.present && ({1'b0, m_rdata.slot} < cnt_ff)) begin
               h_raddr = m_rdata.slot;
               pos_in = m_rdata.slot;
               state_in = S_ADD_CK;
            end else if (cnt_ff >= CW'(imq_pkg::HEAP_DEPTH)) begin
               stat_in = imq_pkg::STAT_FULL;
               state_in = S_FIN;
            end else begin
               pos_in = cnt_ff[SW-1:0];
               cnt_in = cnt_ff + CW'(1);
               cur_in = '{value: amt_ff, key: key_ff};
               m_we = 1'b1;
               m_wdata = '{present: 1'b1, slot: cnt_ff[SW-1:0]};
               moved_in = 1'b0;
               add_in = 1'b0;
               state_in = S_UP_RD;
            end
         end
         S_ADD_CK: begin
            old_in = h_rdata.value;
            cur_in = '{value: sat_val, key: h_rdata.key};
            moved_in = 1'b0;
            add_in = 1'b1;
            state_in = S_UP_RD;
         end
         S_POP_RD: begin
            okey_in = h_rdata.key;
            oval_in = h_rdata.value;
            k_we = 1'b1;
            k_wdata = 1'b1;
            m_we = 1'b1;
            m_waddr = h_rdata.key;
            h_raddr = SW'(cnt_ff - CW'(1));
            cnt_in = cnt_ff - CW'(1);
            state_in = S_POP_CK;
         end
         S_POP_CK: begin
            if (cnt_ff == '0) begin
               state_in = S_FIN;
            end else begin
               cur_in = h_rdata;
               pos_in = '0;
               m_we = 1'b1;
               m_waddr = h_rdata.key;
               m_wdata = '{present: 1'b1, slot: '0};
               state_in = S_DN_A;
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               if (!moved_ff && add_ff && (cur_ff.value < old_ff)) begin
                  state_in = S_DN_A;
               end else begin
                  h_we = 1'b1;
                  state_in = S_FIN;
               end
            end else begin
               h_raddr = par_idx;
               state_in = S_UP_CK;
            end
         end
         S_UP_CK: begin
            if (h_rdata.value < cur_ff.value) begin
               h_we = 1'b1;
               h_wdata = h_rdata;
               m_we = 1'b1;
               m_waddr = cur_ff.key;
               m_wdata = '{present: 1'b1, slot: par_idx};
               hold_in = h_rdata;
               state_in = S_UP_MV;
            end else if (!moved_ff && add_ff && (cur_ff.value < old_ff)) begin
               state_in = S_DN_A;
            end else begin
               h_we = 1'b1;
               state_in = S_FIN;
            end
         end
         S_UP_MV: begin
            m_we = 1'b1;
            m_waddr = hold_ff.key;
            m_wdata = '{present: 1'b1, slot: pos_ff};
            pos_in = par_idx;
            moved_in = 1'b1;
            state_in = S_UP_RD;
         end
         S_DN_A: begin
            if (c1_idx >= {1'b0, cnt_ff}) begin
               h_we = 1'b1;
               state_in = S_FIN;
            end else begin
               h_raddr = c1_idx[SW-1:0];
               state_in = S_DN_B;
            end
         end
         S_DN_B: begin
            hold_in = h_rdata;
            h_raddr = c2_idx[SW-1:0];
            state_in = S_DN_C;
         end
         S_DN_C: begin
            if (cur_ff.value >= child.value) begin
               h_we = 1'b1;
               state_in = S_FIN;
            end else begin
               h_we = 1'b1;
               h_wdata = child;
               m_we = 1'b1;
               m_waddr = child.key;
               m_wdata = '{present: 1'b1, slot: pos_ff};
               pos_in = pick1 ? c1_idx[SW-1:0] : c2_idx[SW-1:0];
               state_in = S_DN_D;
            end
         end
         S_DN_D: begin
            m_we = 1'b1;
            m_waddr = cur_ff.key;
            m_wdata = '{present: 1'b1, slot: pos_ff};
            state_in = S_DN_A;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in = stat_ff;
               rsp_key_in = okey_ff;
               rsp_val_in = oval_ff;
               rsp_cnt_in = cnt_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff <= key_in;
      amt_ff <= amt_in;
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      hold_ff <= hold_in;
      old_ff <= old_in;
      moved_ff <= moved_in;
      add_ff <= add_in;
      stat_ff <= stat_in;
      okey_ff <= okey_in;
      oval_ff <= oval_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_key_ff <= rsp_key_in;
      rsp_val_ff <= rsp_val_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   imq_ram #(.WIDTH(HW), .DEPTH(imq_pkg::HEAP_DEPTH)) u_heap_ram (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_addr (h_raddr),
      .rd_data (h_rdata)
   );

   imq_ram #(.WIDTH(MW), .DEPTH(imq_pkg::KEY_SPACE)) u_map_ram (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (m_waddr),
      .wr_data (m_wdata),
      .rd_addr (m_raddr),
      .rd_data (m_rdata)
   );

   imq_ram #(.WIDTH(1), .DEPTH(imq_pkg::KEY_SPACE)) u_mark_ram (
      .clock   (clock),
      .wr_en   (k_we),
      .wr_addr (m_waddr),
      .wr_data (k_wdata),
      .rd_addr (m_raddr),
      .rd_data (k_rdata)
   );

   `IMQ_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(imq_pkg::HEAP_DEPTH))
   `IMQ_ASSERT_IMP(a_pos_live, clock, reset, walking, {1'b0, pos_ff} < cnt_ff)
   `IMQ_ASSERT_NXT(a_cnt_step, clock, reset, !reset, cnt_ff == $past(cnt_ff) || cnt_ff == $past(cnt_ff) + CW'(1) || cnt_ff == $past(cnt_ff) - CW'(1))
endmodule
`default_nettype wire

// ===== hw/rtl/imq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module imq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
